// ===== hw/rtl/priority_queue_least_loaded_dispatch_core_defines.svh =====
// Assertion helpers shared by the dispatcher RTL.
// Each macro expects clk and arst_n in the scope where it is used.
`ifndef PRIORITY_QUEUE_LEAST_LOADED_DISPATCH_CORE_DEFINES_SVH
`define PRIORITY_QUEUE_LEAST_LOADED_DISPATCH_CORE_DEFINES_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define PQLD_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
// next-cycle implication
`define PQLD_ASSERT_NXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define PQLD_ASSERT_NOW(label, ante, cons, msg)
`define PQLD_ASSERT_NXT(label, ante, cons, msg)
`endif

`endif

// ===== hw/rtl/pqld_pkg.sv =====
`timescale 1ns / 1ps

package pqld_pkg;

	// Sizing
	localparam int NUM_QUEUES  = 4;
	localparam int QUEUE_DEPTH = 8;
	localparam int NUM_SLOTS   = 8;
	localparam int PRIO_SHIFT  = 6;
	localparam int PRIO_MAX    = 255;

	localparam int MASK_W = 8;
	localparam int ID_W   = 16;
	localparam int LOAD_W = 16;
	localparam int PRIO_W = 12;

	localparam int Q_W    = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
	localparam int P_W    = $clog2(QUEUE_DEPTH);
	localparam int C_W    = $clog2(QUEUE_DEPTH + 1);
	localparam int SLOT_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
	localparam int RAM_DEPTH = NUM_QUEUES * QUEUE_DEPTH;
	localparam int A_W    = (RAM_DEPTH > 1) ? $clog2(RAM_DEPTH) : 1;

	typedef enum logic [1:0] {
		CMD_SUBMIT   = 2'd0,
		CMD_DISPATCH = 2'd1,
		CMD_STATUS   = 2'd2,
		CMD_NONE     = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		KIND_ACCEPT = 2'd0,
		KIND_REJECT = 2'd1,
		KIND_GRANT  = 2'd2,
		KIND_END    = 2'd3
	} kind_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DSP_CHECK,
		ST_DSP_READ,
		ST_DSP_SCAN,
		ST_EMIT
	} state_t;

	// Queued workload
	typedef struct packed {
		logic [ID_W-1:0]   id;
		logic [MASK_W-1:0] mask;
	} entry_t;

	// Slot status write
	typedef struct packed {
		logic              en;
		logic [2:0]        slot;
		logic              enabled;
		logic              available;
		logic [LOAD_W-1:0] load;
	} slot_wr_t;

	// Scan result
	typedef struct packed {
		logic              done;
		logic              found;
		logic [SLOT_W-1:0] slot;
	} scan_res_t;

	// Flat store address of queue q, position ptr
	function automatic logic [A_W-1:0] ram_addr(input logic [Q_W-1:0] q,
	                                             input logic [P_W-1:0] ptr);
		ram_addr = A_W'(A_W'(q) * QUEUE_DEPTH) + A_W'(ptr);
	endfunction

	// Ring pointer advance
	function automatic logic [P_W-1:0] ptr_inc(input logic [P_W-1:0] ptr);
		ptr_inc = (ptr == P_W'(QUEUE_DEPTH - 1)) ? '0 : ptr + P_W'(1);
	endfunction

endpackage

// ===== hw/rtl/pqld_queue_ram.sv =====
`timescale 1ns / 1ps

// Shared store for all queues: one write port, one registered read port
module pqld_queue_ram
	import pqld_pkg::*;
(
	input  logic           clk,
	input  logic           we,
	input  logic [A_W-1:0] waddr,
	input  entry_t         wdata,
	input  logic           re,
	input  logic [A_W-1:0] raddr,
	output entry_t         rdata
);

	entry_t mem_q [RAM_DEPTH];
	entry_t rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ===== hw/rtl/pqld_slot_scan.sv =====
`timescale 1ns / 1ps
`include "priority_queue_least_loaded_dispatch_core_defines.svh"

// GPU slot table plus a single compare unit that walks the slots one per cycle
module pqld_slot_scan
	import pqld_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  slot_wr_t          wr,
	input  logic              start,
	input  logic [MASK_W-1:0] mask,
	output scan_res_t         res
);

	logic              en_q   [NUM_SLOTS];
	logic              av_q   [NUM_SLOTS];
	logic [LOAD_W-1:0] load_q [NUM_SLOTS];

	logic              busy_q;
	logic              done_q;
	logic [SLOT_W-1:0] idx_q;
	logic [MASK_W-1:0] mask_q;
	logic              found_q;
	logic [LOAD_W-1:0] best_q;
	logic [SLOT_W-1:0] best_slot_q;

	logic [MASK_W-1:0] mask_sh;
	logic              cand;
	logic              wr_ok;
	logic [SLOT_W-1:0] wr_idx;

	// Slot status table
	assign wr_ok  = wr.en && (32'(wr.slot) < NUM_SLOTS);
	assign wr_idx = SLOT_W'(wr.slot);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_SLOTS; i++) begin
				en_q[i]   <= 1'b0;
				av_q[i]   <= 1'b0;
				load_q[i] <= '0;
			end
		end else if (wr_ok) begin
			en_q[wr_idx]   <= wr.enabled;
			av_q[wr_idx]   <= wr.available;
			load_q[wr_idx] <= wr.load;
		end
	end

	// Compare unit: slots beyond the mask width shift out as zero
	assign mask_sh = mask_q >> idx_q;
	assign cand    = mask_sh[0] && en_q[idx_q] && av_q[idx_q]
	                 && (!found_q || (load_q[idx_q] < best_q));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			done_q  <= 1'b0;
			idx_q   <= '0;
			found_q <= 1'b0;
		end else if (start) begin
			busy_q  <= 1'b1;
			done_q  <= 1'b0;
			idx_q   <= '0;
			found_q <= 1'b0;
		end else if (busy_q) begin
			if (cand) begin
				found_q <= 1'b1;
			end
			if (idx_q == SLOT_W'(NUM_SLOTS - 1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end else begin
				idx_q <= idx_q + SLOT_W'(1);
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	// Scan payload
	always_ff @(posedge clk) begin
		if (start) begin
			mask_q <= mask;
		end
		if (busy_q && cand) begin
			best_q      <= load_q[idx_q];
			best_slot_q <= idx_q;
		end
	end

	assign res.done  = done_q;
	assign res.found = found_q;
	assign res.slot  = best_slot_q;

	`PQLD_ASSERT_NXT(a_done_pulse, done_q, !done_q, "scan done held more than one cycle")
	`PQLD_ASSERT_NOW(a_no_restart, start, !busy_q, "scan started while busy")
	`PQLD_ASSERT_NOW(a_pick_ok, done_q && found_q, en_q[best_slot_q] && av_q[best_slot_q], "picked slot not usable")

endmodule

// ===== hw/rtl/priority_queue_least_loaded_dispatch_core.sv =====
`timescale 1ns / 1ps
`include "priority_queue_least_loaded_dispatch_core_defines.svh"

// Submit: accepted in idle; the word enters the output register from the emit state.
// Dispatch: a head check for each empty queue visited; each head goes through head
//   check, store read, slot scan by the shared compare unit and emit, in that order.
// Status: no word. Input stalls until all words of an item are queued.
// arst_n clears queue pointers, counts, slot table and sets the id counter to one.
module priority_queue_least_loaded_dispatch_core
	import pqld_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic [1:0]        command,
	input  logic [PRIO_W-1:0] priority_req,
	input  logic [MASK_W-1:0] allowed_mask,
	input  logic [2:0]        slot,
	input  logic              slot_enabled,
	input  logic              slot_available,
	input  logic [LOAD_W-1:0] slot_load,
	output logic              out_valid,
	input  logic              out_stall,
	output logic [1:0]        kind,
	output logic [ID_W-1:0]   job_id,
	output logic [2:0]        granted_slot,
	output logic [1:0]        queue_number,
	output logic              stalled,
	output logic              last
);

	state_t state_q, state_d;

	logic [P_W-1:0] head_q [NUM_QUEUES];
	logic [P_W-1:0] tail_q [NUM_QUEUES];
	logic [C_W-1:0] cnt_q  [NUM_QUEUES];
	logic [ID_W-1:0] next_id_q;
	logic [Q_W-1:0]  q_idx_q;
	entry_t          ent_q;

	// pending word
	kind_t           pend_kind_q;
	logic [ID_W-1:0] pend_id_q;
	logic [2:0]      pend_slot_q;
	logic [Q_W-1:0]  pend_q_q;
	logic            pend_stalled_q;
	logic            pend_last_q;

	// output register
	logic            out_valid_q;
	kind_t           kind_q;
	logic [ID_W-1:0] job_id_q;
	logic [2:0]      granted_slot_q;
	logic [Q_W-1:0]  queue_number_q;
	logic            stalled_q;
	logic            last_q;

	logic              in_acc;
	cmd_t              cmd;
	logic [PRIO_W-1:0] prio_c;
	logic [PRIO_W-1:0] q_raw;
	logic [Q_W-1:0]    sub_q;
	logic [Q_W-1:0]    sel_q;
	logic [P_W-1:0]    head_sel;
	logic [P_W-1:0]    tail_sel;
	logic [C_W-1:0]    cnt_sel;
	logic              full_sel;
	logic              out_free;

	logic              do_submit;
	logic              do_dispatch;
	logic              out_load;
	logic              ram_we;
	logic              ram_re;
	logic [A_W-1:0]    ram_waddr;
	logic [A_W-1:0]    ram_raddr;
	entry_t            ram_wdata;
	entry_t            ram_rdata;
	logic              scan_start;
	slot_wr_t          slot_wr;
	scan_res_t         scan_res;

	// Input decode and queue selection
	assign in_stall = (state_q != ST_IDLE);
	assign in_acc   = in_valid && !in_stall;
	assign cmd      = cmd_t'(command);

	assign prio_c = (priority_req > PRIO_W'(PRIO_MAX)) ? PRIO_W'(PRIO_MAX) : priority_req;
	assign q_raw  = prio_c >> PRIO_SHIFT;
	assign sub_q  = (q_raw >= PRIO_W'(NUM_QUEUES)) ? Q_W'(NUM_QUEUES - 1) : Q_W'(q_raw);

	assign sel_q    = (state_q == ST_IDLE) ? sub_q : q_idx_q;
	assign head_sel = head_q[sel_q];
	assign tail_sel = tail_q[sel_q];
	assign cnt_sel  = cnt_q[sel_q];
	assign full_sel = (cnt_sel >= C_W'(QUEUE_DEPTH));

	assign out_free = !out_valid_q || !out_stall;

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_acc && (cmd == CMD_SUBMIT)) begin
					state_d = ST_EMIT;
				end else if (in_acc && (cmd == CMD_DISPATCH)) begin
					state_d = ST_DSP_CHECK;
				end
			end
			ST_DSP_CHECK: begin
				if (cnt_sel != '0) begin
					state_d = ST_DSP_READ;
				end else if (q_idx_q == '0) begin
					state_d = ST_EMIT;
				end
			end
			ST_DSP_READ: state_d = ST_DSP_SCAN;
			ST_DSP_SCAN: begin
				if (scan_res.done) begin
					state_d = ST_EMIT;
				end
			end
			ST_EMIT: begin
				if (out_free) begin
					state_d = pend_last_q ? ST_IDLE : ST_DSP_CHECK;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Sequencer outputs
	always_comb begin
		do_submit   = 1'b0;
		do_dispatch = 1'b0;
		out_load    = 1'b0;
		ram_we      = 1'b0;
		ram_re      = 1'b0;
		ram_waddr   = ram_addr(sel_q, tail_sel);
		ram_raddr   = ram_addr(sel_q, head_sel);
		ram_wdata   = ent_q;
		scan_start  = 1'b0;
		slot_wr.en        = 1'b0;
		slot_wr.slot      = slot;
		slot_wr.enabled   = slot_enabled;
		slot_wr.available = slot_available;
		slot_wr.load      = slot_load;
		unique case (state_q)
			ST_IDLE: begin
				if (in_acc) begin
					unique case (cmd)
						CMD_SUBMIT: begin
							do_submit      = 1'b1;
							ram_we         = !full_sel;
							ram_wdata.id   = next_id_q;
							ram_wdata.mask = allowed_mask;
						end
						CMD_DISPATCH: do_dispatch = 1'b1;
						CMD_STATUS:   slot_wr.en  = 1'b1;
						default: ;
					endcase
				end
			end
			ST_DSP_CHECK: ram_re = (cnt_sel != '0);
			ST_DSP_READ:  scan_start = 1'b1;
			ST_DSP_SCAN:  ram_we = scan_res.done && !scan_res.found;
			ST_EMIT:      out_load = out_free;
			default: ;
		endcase
	end

	// Control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			next_id_q   <= ID_W'(1);
			q_idx_q     <= '0;
			out_valid_q <= 1'b0;
			for (int i = 0; i < NUM_QUEUES; i++) begin
				head_q[i] <= '0;
				tail_q[i] <= '0;
				cnt_q[i]  <= '0;
			end
		end else begin
			state_q <= state_d;
			if (do_submit) begin
				next_id_q <= next_id_q + ID_W'(1);
				if (!full_sel) begin
					tail_q[sel_q] <= ptr_inc(tail_sel);
					cnt_q[sel_q]  <= cnt_sel + C_W'(1);
				end
			end
			if (do_dispatch) begin
				q_idx_q <= Q_W'(NUM_QUEUES - 1);
			end
			if ((state_q == ST_DSP_CHECK) && (cnt_sel == '0) && (q_idx_q != '0)) begin
				q_idx_q <= q_idx_q - Q_W'(1);
			end
			if ((state_q == ST_DSP_SCAN) && scan_res.done) begin
				head_q[sel_q] <= ptr_inc(head_sel);
				if (scan_res.found) begin
					cnt_q[sel_q] <= cnt_sel - C_W'(1);
				end else begin
					tail_q[sel_q] <= ptr_inc(tail_sel);
				end
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Pending word and output payload
	always_ff @(posedge clk) begin
		if (state_q == ST_DSP_READ) begin
			ent_q <= ram_rdata;
		end
		if (do_submit) begin
			pend_kind_q    <= full_sel ? KIND_REJECT : KIND_ACCEPT;
			pend_id_q      <= next_id_q;
			pend_slot_q    <= '0;
			pend_q_q       <= sub_q;
			pend_stalled_q <= 1'b0;
			pend_last_q    <= 1'b1;
		end
		if ((state_q == ST_DSP_CHECK) && (cnt_sel == '0) && (q_idx_q == '0)) begin
			pend_kind_q    <= KIND_END;
			pend_id_q      <= '0;
			pend_slot_q    <= '0;
			pend_q_q       <= '0;
			pend_stalled_q <= 1'b0;
			pend_last_q    <= 1'b1;
		end
		if ((state_q == ST_DSP_SCAN) && scan_res.done) begin
			pend_q_q <= q_idx_q;
			if (scan_res.found) begin
				pend_kind_q    <= KIND_GRANT;
				pend_id_q      <= ent_q.id;
				pend_slot_q    <= 3'(scan_res.slot);
				pend_stalled_q <= 1'b0;
				pend_last_q    <= 1'b0;
			end else begin
				pend_kind_q    <= KIND_END;
				pend_id_q      <= '0;
				pend_slot_q    <= '0;
				pend_stalled_q <= 1'b1;
				pend_last_q    <= 1'b1;
			end
		end
		if (out_load) begin
			kind_q         <= pend_kind_q;
			job_id_q       <= pend_id_q;
			granted_slot_q <= pend_slot_q;
			queue_number_q <= pend_q_q;
			stalled_q      <= pend_stalled_q;
			last_q         <= pend_last_q;
		end
	end

	assign out_valid    = out_valid_q;
	assign kind         = kind_q;
	assign job_id       = job_id_q;
	assign granted_slot = granted_slot_q;
	assign queue_number = 2'(queue_number_q);
	assign stalled      = stalled_q;
	assign last         = last_q;

	// Queue store
	pqld_queue_ram u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// Slot table and least-load scan
	pqld_slot_scan u_scan (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (slot_wr),
		.start  (scan_start),
		.mask   (ram_rdata.mask),
		.res    (scan_res)
	);

	`PQLD_ASSERT_NOW(a_scan_state, scan_res.done, state_q == ST_DSP_SCAN, "scan result outside scan state")
	`PQLD_ASSERT_NOW(a_grant_not_last, out_valid_q && (kind_q == KIND_GRANT), !last_q, "grant word marked last")
	`PQLD_ASSERT_NOW(a_out_from_emit, $rose(out_valid_q), $past(state_q == ST_EMIT), "word loaded outside emit")
	`PQLD_ASSERT_NOW(a_cnt_range, 1'b1, cnt_sel <= C_W'(QUEUE_DEPTH), "queue count above depth")

endmodule

// ===== dv/priority_queue_least_loaded_dispatch_core_test.sv =====
`timescale 1ns / 1ps

module priority_queue_least_loaded_dispatch_core_test;
	import pqld_pkg::*;

	localparam int QUIET_LIMIT   = 2000;
	localparam int SETTLE_CYCLES = 4 * (NUM_SLOTS + 4);
	localparam int RANDOM_WORDS  = 80;

	// One output word as seen on the result channel
	typedef struct packed {
		kind_t           kind;
		logic [ID_W-1:0] id;
		logic [2:0]      gslot;
		logic [1:0]      q;
		logic            stl;
		logic            lst;
	} result_t;

	// Dispatcher state mirror plus the list of words still owed by the block
	class dispatch_scoreboard;
		entry_t            ring[NUM_QUEUES][QUEUE_DEPTH];
		int unsigned       rd_ptr[NUM_QUEUES];
		int unsigned       wr_ptr[NUM_QUEUES];
		int unsigned       fill[NUM_QUEUES];
		logic [ID_W-1:0]   next_id;
		bit                gpu_on[NUM_SLOTS];
		bit                gpu_free[NUM_SLOTS];
		logic [LOAD_W-1:0] gpu_util[NUM_SLOTS];
		result_t           pending[$];
		int                errors, words_in, grants, stalls, rejects;

		function new();
			next_id = 1;
			foreach (gpu_util[i])
				gpu_util[i] = '0;
		endfunction

		// Enabled, available slot in the mask with the strictly lowest load; -1 if none
		function int least_loaded(logic [MASK_W-1:0] mask);
			logic [31:0] best;
			int chosen;
			best = '1;
			chosen = -1;
			for (int i = 0; i < NUM_SLOTS; i++) begin
				if (i < MASK_W && mask[i] && gpu_on[i] && gpu_free[i] &&
				    32'(gpu_util[i]) < best) begin
					best = 32'(gpu_util[i]);
					chosen = i;
				end
			end
			return chosen;
		endfunction

		function void push(kind_t k, logic [ID_W-1:0] job, int unsigned gs, int unsigned q,
		                   bit stl, bit lst);
			result_t r;
			r.kind  = k;
			r.id    = job;
			r.gslot = gs[2:0];
			r.q     = q[1:0];
			r.stl   = stl;
			r.lst   = lst;
			pending.push_back(r);
		endfunction

		// Accepted input word: update the mirror and queue the words it causes
		function void note_word(cmd_t cmd, logic [PRIO_W-1:0] prio, logic [MASK_W-1:0] mask,
		                        logic [2:0] s, logic e, logic a, logic [LOAD_W-1:0] l);
			int unsigned p, q;
			int qi, pick;
			logic [ID_W-1:0] job;
			entry_t head;
			bit blocked;
			words_in++;
			case (cmd)
				CMD_SUBMIT: begin
					job = next_id;
					next_id = next_id + 1'b1;
					p = (prio > PRIO_MAX) ? PRIO_MAX : prio;
					q = p >> PRIO_SHIFT;
					if (q >= NUM_QUEUES)
						q = NUM_QUEUES - 1;
					if (fill[q] >= QUEUE_DEPTH) begin
						rejects++;
						push(KIND_REJECT, job, 0, q, 0, 1);
					end else begin
						ring[q][wr_ptr[q]] = '{id: job, mask: mask};
						wr_ptr[q] = (wr_ptr[q] + 1) % QUEUE_DEPTH;
						fill[q]++;
						push(KIND_ACCEPT, job, 0, q, 0, 1);
					end
				end
				CMD_DISPATCH: begin
					blocked = 0;
					// highest queue first; a head with no slot goes to the tail and ends it
					for (qi = NUM_QUEUES - 1; qi >= 0 && !blocked; qi--) begin
						while (fill[qi] > 0 && !blocked) begin
							head = ring[qi][rd_ptr[qi]];
							pick = least_loaded(head.mask);
							rd_ptr[qi] = (rd_ptr[qi] + 1) % QUEUE_DEPTH;
							if (pick < 0) begin
								ring[qi][wr_ptr[qi]] = head;
								wr_ptr[qi] = (wr_ptr[qi] + 1) % QUEUE_DEPTH;
								stalls++;
								push(KIND_END, 0, 0, qi, 1, 1);
								blocked = 1;
							end else begin
								fill[qi]--;
								grants++;
								push(KIND_GRANT, head.id, pick, qi, 0, 0);
							end
						end
					end
					if (!blocked)
						push(KIND_END, 0, 0, 0, 0, 1);
				end
				CMD_STATUS: begin
					if (s < NUM_SLOTS) begin
						gpu_on[s]   = e;
						gpu_free[s] = a;
						gpu_util[s] = l;
					end
				end
				default: ;
			endcase
		endfunction

		function void compare(string name, logic [31:0] exp, logic [31:0] act);
			if (exp !== act) begin
				errors++;
				$display("%0t: %s mismatch, expected %0h actual %0h", $time, name, exp, act);
			end
		endfunction

		// Accepted output word against the oldest owed word
		function void check_word(result_t got);
			result_t want;
			if (pending.size() == 0) begin
				errors++;
				$display("%0t: unexpected word, expected none actual kind %0d id %0h",
				         $time, got.kind, got.id);
				return;
			end
			want = pending.pop_front();
			compare("kind", 32'(want.kind), 32'(got.kind));
			compare("job_id", 32'(want.id), 32'(got.id));
			compare("granted_slot", 32'(want.gslot), 32'(got.gslot));
			compare("queue_number", 32'(want.q), 32'(got.q));
			compare("stalled", 32'(want.stl), 32'(got.stl));
			compare("last", 32'(want.lst), 32'(got.lst));
		endfunction
	endclass

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              in_valid = 1'b0;
	logic              in_stall;
	logic [1:0]        command = CMD_NONE;
	logic [PRIO_W-1:0] priority_req = '0;
	logic [MASK_W-1:0] allowed_mask = '0;
	logic [2:0]        slot = '0;
	logic              slot_enabled = 1'b0;
	logic              slot_available = 1'b0;
	logic [LOAD_W-1:0] slot_load = '0;
	logic              out_valid;
	logic              out_stall = 1'b0;
	logic [1:0]        kind;
	logic [ID_W-1:0]   job_id;
	logic [2:0]        granted_slot;
	logic [1:0]        queue_number;
	logic              stalled;
	logic              last;

	dispatch_scoreboard sb = new();
	bit no_gaps;
	int stall_left;
	int quiet;

	priority_queue_least_loaded_dispatch_core dut (.*);

	always #6 clk = ~clk;

	// Monitor: record accepted words, check results, pace the receiver, watchdog
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && !in_stall)
				sb.note_word(cmd_t'(command), priority_req, allowed_mask, slot, slot_enabled,
				             slot_available, slot_load);
			if (out_valid && !out_stall) begin
				sb.check_word('{kind_t'(kind), job_id, granted_slot, queue_number, stalled, last});
				stall_left = no_gaps ? 0 : $urandom_range(0, 9);
				if (stall_left > 0)
					out_stall <= 1'b1;
			end else if (out_stall) begin
				stall_left--;
				if (stall_left <= 0)
					out_stall <= 1'b0;
			end
			if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
				quiet = 0;
			end else begin
				quiet++;
				if (quiet >= QUIET_LIMIT) begin
					$display("%0t: no handshake for %0d cycles", $time, QUIET_LIMIT);
					$display("priority_queue_least_loaded_dispatch_core_test: FAIL");
					$finish;
				end
			end
		end
	end

	// Present one input word after a random gap and hold it until accepted
	task automatic send_word(input cmd_t c, input logic [PRIO_W-1:0] p,
	                         input logic [MASK_W-1:0] m, input logic [2:0] s, input logic e,
	                         input logic a, input logic [LOAD_W-1:0] l);
		int gap;
		gap = no_gaps ? 0 : $urandom_range(0, 9);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid       <= 1'b1;
		command        <= c;
		priority_req   <= p;
		allowed_mask   <= m;
		slot           <= s;
		slot_enabled   <= e;
		slot_available <= a;
		slot_load      <= l;
		@(posedge clk);
		while (in_stall) @(posedge clk);
	endtask

	// Shorthand for words whose unused fields carry noise
	task automatic send_cmd(input cmd_t c);
		send_word(c, PRIO_W'($urandom), MASK_W'($urandom), 3'($urandom), 1'($urandom),
		          1'($urandom), LOAD_W'($urandom));
	endtask

	task automatic send_submit(input logic [PRIO_W-1:0] p, input logic [MASK_W-1:0] m);
		send_word(CMD_SUBMIT, p, m, 3'($urandom), 1'($urandom), 1'($urandom),
		          LOAD_W'($urandom));
	endtask

	task automatic send_status(input logic [2:0] s, input logic e, input logic a,
	                           input logic [LOAD_W-1:0] l);
		send_word(CMD_STATUS, PRIO_W'($urandom), MASK_W'($urandom), s, e, a, l);
	endtask

	// Let every owed word come back, then give a trailing status write time to land
	task automatic wait_idle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Random word: mostly sane submits and slot updates so dispatch gets deep
	task automatic random_word(output bit counted);
		cmd_t c;
		logic [PRIO_W-1:0] p;
		logic [MASK_W-1:0] m;
		logic [LOAD_W-1:0] l;
		int roll;
		roll = $urandom_range(0, 99);
		c = (roll < 45) ? CMD_SUBMIT : (roll < 65) ? CMD_DISPATCH :
		    (roll < 95) ? CMD_STATUS : CMD_NONE;
		p = ($urandom_range(0, 9) < 7) ? PRIO_W'($urandom_range(0, 255)) :
		    PRIO_W'($urandom_range(0, 4095));
		case ($urandom_range(0, 19))
			// unusable workload kept in the lowest queue so it cannot block the rest
			0: begin
				m = '0;
				p = PRIO_W'($urandom_range(0, 63));
			end
			1, 2, 3: m = '1;
			4, 5, 6: m = 8'h01 << $urandom_range(0, 7);
			default: m = MASK_W'($urandom);
		endcase
		case ($urandom_range(0, 3))
			0, 1: l = LOAD_W'($urandom_range(0, 3));
			2: l = LOAD_W'($urandom);
			default: l = $urandom_range(0, 1) ? '1 : '0;
		endcase
		send_word(c, p, m, 3'($urandom_range(0, 7)), $urandom_range(0, 4) != 0,
		          $urandom_range(0, 4) != 0, l);
		counted = (c != CMD_NONE);
	endtask

	task automatic random_phase(input int words);
		int done;
		bit counted;
		done = 0;
		while (done < words) begin
			random_word(counted);
			if (counted) begin
				done++;
				if (done % 20 == 0)
					no_gaps = ($urandom_range(0, 3) == 0);
			end
		end
		no_gaps = 0;
	endtask

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: empty dispatch, clamping, no slot, ties, flags, unused command
		send_cmd(CMD_DISPATCH);
		send_submit(12'd0, 8'hFF);
		send_submit(12'hFFF, 8'h01);
		send_submit(12'd64, 8'h80);
		send_submit(12'd191, 8'h28);
		send_submit(12'd256, 8'hFF);
		send_cmd(CMD_DISPATCH);
		send_status(3'd0, 1'b1, 1'b1, 16'hFFFF);
		send_status(3'd3, 1'b1, 1'b1, 16'd5);
		send_status(3'd5, 1'b1, 1'b1, 16'd5);
		send_status(3'd7, 1'b1, 1'b0, 16'd0);
		send_status(3'd6, 1'b0, 1'b1, 16'd0);
		send_cmd(CMD_NONE);
		send_submit(12'd200, 8'hE8);
		send_submit(12'hFFF, 8'hC0);
		send_cmd(CMD_DISPATCH);
		send_status(3'd7, 1'b1, 1'b1, 16'd0);
		send_cmd(CMD_DISPATCH);
		send_submit(12'd0, 8'h00);
		send_status(3'd1, 1'b1, 1'b1, 16'd0);
		send_status(3'd2, 1'b1, 1'b1, 16'd0);
		send_status(3'd4, 1'b1, 1'b1, 16'd9);
		send_cmd(CMD_DISPATCH);

		random_phase(RANDOM_WORDS);

		// Fill the lowest queue past its depth, then drain the upper queues
		wait_idle();
		repeat (QUEUE_DEPTH + 1)
			send_submit(PRIO_W'($urandom_range(0, 63)), 8'hFF);
		wait_idle();
		repeat (6)
			send_submit(PRIO_W'($urandom_range(64, 255)), 8'hFF);
		send_cmd(CMD_DISPATCH);

		random_phase(RANDOM_WORDS);

		wait_idle();
		$display("Covered %0d input words: %0d grants, %0d dispatches stopped on a head,",
		         sb.words_in, sb.grants, sb.stalls);
		$display("%0d submits rejected on a full queue.", sb.rejects);
		if (sb.errors == 0 && sb.pending.size() == 0) begin
			$display("priority_queue_least_loaded_dispatch_core_test: PASS");
		end else begin
			$display("%0d mismatches, %0d words never arrived", sb.errors, sb.pending.size());
			$display("priority_queue_least_loaded_dispatch_core_test: FAIL");
		end
		$finish;
	end

endmodule
